>>> rtl/core/spvg_pkg.sv
package spvg_pkg;

   localparam int unsigned DIR_W     = 32;
   localparam int unsigned IDX_W     = 6;
   localparam int unsigned VERT_W    = 33;
   localparam int unsigned TEX_W     = 16;
   localparam int unsigned BOX_W     = 42;
   localparam int unsigned OFS_W     = 41;
   localparam int unsigned RAD_W     = 32;
   localparam int unsigned LVL_W     = 4;
   localparam int unsigned CSR_IDX_W = 3;
   localparam int unsigned CSR_DAT_W = 41;

   // direction sum, its magnitude and the block-normalized magnitude
   localparam int unsigned SUM_W  = 42;
   localparam int unsigned MAG_W  = 41;
   localparam int unsigned NRM_W  = 31;
   localparam int unsigned WIDE_W = 64;
   localparam int unsigned HALF_W = 32;

   localparam int unsigned TEX_BASE      = 32;
   localparam int unsigned TEX_LIMIT     = 512;
   localparam int unsigned TEX_BASE_LOG2 = $clog2(TEX_BASE);
   localparam int unsigned TEX_MAX_SHIFT = $clog2(TEX_LIMIT / TEX_BASE);
   localparam int unsigned TEX_SIZE_W    = $clog2(TEX_LIMIT) + 1;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_RADIUS   = 3'd0,
      CSR_OFFSET_X = 3'd1,
      CSR_OFFSET_Y = 3'd2,
      CSR_OFFSET_Z = 3'd3,
      CSR_LEVEL    = 3'd4
   } csr_index_type;

endpackage

>>> rtl/core/spvg_if.sv
interface spvg_req_if;
   logic                                 valid;
   logic                                 ready;
   logic signed [spvg_pkg::DIR_W-1:0]    centre_x;
   logic signed [spvg_pkg::DIR_W-1:0]    centre_y;
   logic signed [spvg_pkg::DIR_W-1:0]    centre_z;
   logic signed [spvg_pkg::DIR_W-1:0]    across_x;
   logic signed [spvg_pkg::DIR_W-1:0]    across_y;
   logic signed [spvg_pkg::DIR_W-1:0]    across_z;
   logic signed [spvg_pkg::DIR_W-1:0]    down_x;
   logic signed [spvg_pkg::DIR_W-1:0]    down_y;
   logic signed [spvg_pkg::DIR_W-1:0]    down_z;
   logic        [spvg_pkg::IDX_W-1:0]    grid_row;
   logic        [spvg_pkg::IDX_W-1:0]    grid_col;

   modport source (output valid, centre_x, centre_y, centre_z, across_x, across_y, across_z,
                   down_x, down_y, down_z, grid_row, grid_col, input ready);
   modport sink   (input valid, centre_x, centre_y, centre_z, across_x, across_y, across_z,
                   down_x, down_y, down_z, grid_row, grid_col, output ready);
endinterface

interface spvg_rsp_if;
   logic                                 valid;
   logic                                 ready;
   logic signed [spvg_pkg::VERT_W-1:0]   vertex_x;
   logic signed [spvg_pkg::VERT_W-1:0]   vertex_y;
   logic signed [spvg_pkg::VERT_W-1:0]   vertex_z;
   logic        [spvg_pkg::TEX_W-1:0]    tex_s;
   logic        [spvg_pkg::TEX_W-1:0]    tex_t;
   logic signed [spvg_pkg::BOX_W-1:0]    box_min_x;
   logic signed [spvg_pkg::BOX_W-1:0]    box_max_x;
   logic signed [spvg_pkg::BOX_W-1:0]    box_min_y;
   logic signed [spvg_pkg::BOX_W-1:0]    box_max_y;
   logic signed [spvg_pkg::BOX_W-1:0]    box_min_z;
   logic signed [spvg_pkg::BOX_W-1:0]    box_max_z;
   logic                                 patch_done;

   modport source (output valid, vertex_x, vertex_y, vertex_z, tex_s, tex_t, box_min_x,
                   box_max_x, box_min_y, box_max_y, box_min_z, box_max_z, patch_done,
                   input ready);
   modport sink   (input valid, vertex_x, vertex_y, vertex_z, tex_s, tex_t, box_min_x,
                   box_max_x, box_min_y, box_max_y, box_min_z, box_max_z, patch_done,
                   output ready);
endinterface

>>> rtl/core/spvg_div.sv
module spvg_div (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             start,
   input  logic [spvg_pkg::WIDE_W-1:0]      dividend,
   input  logic [spvg_pkg::HALF_W-1:0]      divisor,
   output logic                             done,
   output logic [spvg_pkg::WIDE_W-1:0]      quotient
);

   localparam int unsigned WW    = spvg_pkg::WIDE_W;
   localparam int unsigned HW    = spvg_pkg::HALF_W;
   localparam int unsigned CNT_W = $clog2(WW);

   logic              run_ff, run_in;
   logic              done_ff, done_in;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;
   logic [HW-1:0]     rem_ff, rem_in;
   logic [HW-1:0]     dvs_ff, dvs_in;
   logic [WW-1:0]     quo_ff, quo_in;
   logic [HW:0]       rem_sh;
   logic              ge;

   // restoring division, one quotient bit a cycle
   always_comb begin
      rem_sh  = {rem_ff, quo_ff[WW-1]};
      ge      = rem_sh >= {1'b0, dvs_ff};
      run_in  = run_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      dvs_in  = dvs_ff;
      quo_in  = quo_ff;
      if (start) begin
         run_in = 1'b1;
         cnt_in = '0;
         rem_in = '0;
         dvs_in = divisor;
         quo_in = dividend;
      end else if (run_ff) begin
         rem_in = ge ? HW'(rem_sh - {1'b0, dvs_ff}) : rem_sh[HW-1:0];
         quo_in = {quo_ff[WW-2:0], ge};
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == CNT_W'(WW - 1)) begin
            run_in  = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         run_ff  <= run_in;
         done_ff <= done_in;
      end
      cnt_ff <= cnt_in;
      rem_ff <= rem_in;
      dvs_ff <= dvs_in;
      quo_ff <= quo_in;
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule

>>> rtl/core/sphere_patch_vertex_generator.sv
// channel   dir  handshake            carries
// req_bus   in   valid / ready        patch centre, edge vectors, grid row and column
// rsp_bus   out  valid / ready        vertex, texture s/t, bounding box, patch done
// csr_*     in   csr_we               register index and write data, no read-back
//
// a request holds the block after it is taken for: the direction, block scaling, 3 squares,
// 32 square-root steps, 2 texture products, then five runs of the shared divider (three vertex
// components, two texture coordinates) and issuing the result, which waits while the output
// register still holds an unaccepted result
// req_bus.ready is high only while idle; one finished result waits in the output register
// synchronous active-high reset clears control, registers and the box to zero
module sphere_patch_vertex_generator #(
   parameter int unsigned GRID_SIZE = 32
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_we,
   input  logic [spvg_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [spvg_pkg::CSR_DAT_W-1:0]      csr_wdata,
   spvg_req_if.sink                            req_bus,
   spvg_rsp_if.source                          rsp_bus
);

   localparam int unsigned DW     = spvg_pkg::DIR_W;
   localparam int unsigned IW     = spvg_pkg::IDX_W;
   localparam int unsigned SW     = spvg_pkg::SUM_W;
   localparam int unsigned MW     = spvg_pkg::MAG_W;
   localparam int unsigned NW     = spvg_pkg::NRM_W;
   localparam int unsigned WW     = spvg_pkg::WIDE_W;
   localparam int unsigned HW     = spvg_pkg::HALF_W;
   localparam int unsigned VW     = spvg_pkg::VERT_W;
   localparam int unsigned TW     = spvg_pkg::TEX_W;
   localparam int unsigned BW     = spvg_pkg::BOX_W;
   localparam int unsigned OW     = spvg_pkg::OFS_W;
   localparam int unsigned RW     = spvg_pkg::RAD_W;
   localparam int unsigned LW     = spvg_pkg::LVL_W;
   localparam int unsigned TSW    = spvg_pkg::TEX_SIZE_W;
   localparam int unsigned SQ_W   = 2 * TSW;
   localparam int unsigned FACT_W = IW + 2;
   localparam int unsigned CMP_W  = IW + 1;
   localparam int unsigned SHF_W  = $clog2(spvg_pkg::TEX_MAX_SHIFT + 1);
   localparam int unsigned GT_W   = $clog2(GRID_SIZE + 1) + spvg_pkg::TEX_BASE_LOG2
                                    + spvg_pkg::TEX_MAX_SHIFT;
   localparam int unsigned ROOT_STEPS = WW / 2;
   localparam int unsigned RC_W   = $clog2(ROOT_STEPS);

   typedef enum logic [3:0] {
      ST_IDLE, ST_DIR, ST_NORM, ST_SQR, ST_ROOT, ST_VMUL, ST_VDIV,
      ST_TSQ, ST_TDEN, ST_TMUL, ST_TDIV, ST_OUT
   } state_type;

   state_type              state_ff, state_in;
   logic [1:0]             idx_ff, idx_in;
   logic [RC_W-1:0]        cnt_ff, cnt_in;
   logic signed [DW-1:0]   cen_ff[3], cen_in[3];
   logic signed [DW-1:0]   acr_ff[3], acr_in[3];
   logic signed [DW-1:0]   dwn_ff[3], dwn_in[3];
   logic [IW-1:0]          row_ff, row_in, col_ff, col_in;
   logic [2:0]             neg_ff, neg_in;
   logic [MW-1:0]          mag_ff[3], mag_in[3];
   logic [WW-1:0]          rt_n_ff, rt_n_in, rt_r_ff, rt_r_in, rt_bit_ff, rt_bit_in;
   logic signed [VW-1:0]   vert_ff[3], vert_in[3];
   logic [SQ_W-1:0]        sq_ff, sq_in;
   logic [HW-1:0]          den_ff, den_in;
   logic [TW-1:0]          tex_ff[2], tex_in[2];
   logic [RW-1:0]          radius_ff, radius_in;
   logic signed [OW-1:0]   ofs_ff[3], ofs_in[3];
   logic [LW-1:0]          level_ff, level_in;
   logic signed [BW-1:0]   low_ff[3], low_in[3], high_ff[3], high_in[3];

   logic                   rsp_valid_ff, rsp_valid_in;
   logic signed [VW-1:0]   rsp_vert_ff[3], rsp_vert_in[3];
   logic [TW-1:0]          rsp_tex_ff[2], rsp_tex_in[2];
   logic signed [BW-1:0]   rsp_low_ff[3], rsp_low_in[3], rsp_high_ff[3], rsp_high_in[3];
   logic                   rsp_done_ff, rsp_done_in;

   logic signed [FACT_W-1:0] fac_col, fac_row;
   logic signed [SW-1:0]   w_sum, w_abs;
   logic [MW-1:0]          mag_or;
   logic [HW-1:0]          mul_a, mul_b;
   logic [WW-1:0]          mul_p;
   logic [WW-1:0]          rt_rb;
   logic                   div_start, div_done;
   logic [WW-1:0]          div_dividend, div_quo;
   logic [HW-1:0]          div_divisor, mag_q;
   logic [SHF_W-1:0]       tex_shift;
   logic [TSW-1:0]         tsize, tm2;
   logic [GT_W-1:0]        gt;
   logic signed [BW-1:0]   pos[3];
   logic                   first_pt;

   assign fac_col = $signed({1'b0, col_ff, 1'b0}) - $signed(FACT_W'(GRID_SIZE));
   assign fac_row = $signed(FACT_W'(GRID_SIZE)) - $signed({1'b0, row_ff, 1'b0});

   assign w_sum = SW'(cen_ff[idx_ff]) * $signed(SW'(2 * GRID_SIZE))
                + SW'(acr_ff[idx_ff]) * SW'(fac_col)
                + SW'(dwn_ff[idx_ff]) * SW'(fac_row);
   assign w_abs  = w_sum[SW-1] ? -w_sum : w_sum;
   assign mag_or = mag_ff[0] | mag_ff[1] | mag_ff[2];
   assign rt_rb  = rt_r_ff + rt_bit_ff;

   assign tex_shift = (level_ff > LW'(spvg_pkg::TEX_MAX_SHIFT))
                      ? SHF_W'(spvg_pkg::TEX_MAX_SHIFT) : level_ff[SHF_W-1:0];
   assign tsize = TSW'(spvg_pkg::TEX_BASE) << tex_shift;
   assign tm2   = tsize - TSW'(2);
   assign gt    = GT_W'(GRID_SIZE) << (LW'(spvg_pkg::TEX_BASE_LOG2) + LW'(tex_shift));

   // shared multiplier
   always_comb begin
      mul_a = '0;
      mul_b = '0;
      unique case (state_ff)
         ST_SQR: begin
            mul_a = mag_ff[idx_ff][HW-1:0];
            mul_b = mag_ff[idx_ff][HW-1:0];
         end
         ST_VMUL: begin
            mul_a = mag_ff[idx_ff][HW-1:0];
            mul_b = radius_ff;
         end
         ST_TSQ: begin
            mul_a = HW'(tm2);
            mul_b = HW'(tm2);
         end
         ST_TDEN: begin
            mul_a = HW'(tm2);
            mul_b = HW'(gt);
         end
         ST_TMUL: begin
            mul_a = (idx_ff == 2'd0) ? HW'(col_ff) : HW'(row_ff);
            mul_b = HW'(sq_ff);
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end
   assign mul_p = mul_a * mul_b;

   assign first_pt = (row_ff == '0) && (col_ff == '0);
   always_comb begin
      for (int i = 0; i < 3; i++) begin
         pos[i] = BW'(vert_ff[i]) + BW'(ofs_ff[i]);
      end
   end

   assign mag_q = (rt_r_ff == '0) ? '0 : div_quo[HW-1:0];

   always_comb begin
      state_in     = state_ff;
      idx_in       = idx_ff;
      cnt_in       = cnt_ff;
      cen_in       = cen_ff;
      acr_in       = acr_ff;
      dwn_in       = dwn_ff;
      row_in       = row_ff;
      col_in       = col_ff;
      neg_in       = neg_ff;
      mag_in       = mag_ff;
      rt_n_in      = rt_n_ff;
      rt_r_in      = rt_r_ff;
      rt_bit_in    = rt_bit_ff;
      vert_in      = vert_ff;
      sq_in        = sq_ff;
      den_in       = den_ff;
      tex_in       = tex_ff;
      radius_in    = radius_ff;
      ofs_in       = ofs_ff;
      level_in     = level_ff;
      low_in       = low_ff;
      high_in      = high_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_vert_in  = rsp_vert_ff;
      rsp_tex_in   = rsp_tex_ff;
      rsp_low_in   = rsp_low_ff;
      rsp_high_in  = rsp_high_ff;
      rsp_done_in  = rsp_done_ff;
      div_start    = 1'b0;
      div_dividend = '0;
      div_divisor  = '0;

      if (csr_we) begin
         unique case (csr_index)
            spvg_pkg::CSR_RADIUS:   radius_in = csr_wdata[RW-1:0];
            spvg_pkg::CSR_OFFSET_X: ofs_in[0] = $signed(csr_wdata[OW-1:0]);
            spvg_pkg::CSR_OFFSET_Y: ofs_in[1] = $signed(csr_wdata[OW-1:0]);
            spvg_pkg::CSR_OFFSET_Z: ofs_in[2] = $signed(csr_wdata[OW-1:0]);
            spvg_pkg::CSR_LEVEL:    level_in  = csr_wdata[LW-1:0];
            default:                level_in  = level_ff;
         endcase
      end

      if (rsp_valid_ff && rsp_bus.ready) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_bus.valid) begin
               cen_in   = '{req_bus.centre_x, req_bus.centre_y, req_bus.centre_z};
               acr_in   = '{req_bus.across_x, req_bus.across_y, req_bus.across_z};
               dwn_in   = '{req_bus.down_x, req_bus.down_y, req_bus.down_z};
               row_in   = req_bus.grid_row;
               col_in   = req_bus.grid_col;
               idx_in   = '0;
               state_in = ST_DIR;
            end
         end
         ST_DIR: begin
            neg_in[idx_ff] = w_sum[SW-1];
            mag_in[idx_ff] = w_abs[MW-1:0];
            if (idx_ff == 2'd2) begin
               idx_in   = '0;
               state_in = ST_NORM;
            end else begin
               idx_in = idx_ff + 1'b1;
            end
         end
         ST_NORM: begin
            // block scaling: unless all are zero, the largest magnitude ends with its top bit at NW-1
            if (|mag_or[MW-1:NW]) begin
               for (int i = 0; i < 3; i++) mag_in[i] = mag_ff[i] >> 1;
            end else if ((mag_or != '0) && !mag_or[NW-1]) begin
               for (int i = 0; i < 3; i++) mag_in[i] = mag_ff[i] << 1;
            end else begin
               rt_n_in  = '0;
               state_in = ST_SQR;
            end
         end
         ST_SQR: begin
            rt_n_in = rt_n_ff + mul_p;
            if (idx_ff == 2'd2) begin
               idx_in    = '0;
               cnt_in    = '0;
               rt_r_in   = '0;
               rt_bit_in = WW'(1) << (WW - 2);
               state_in  = ST_ROOT;
            end else begin
               idx_in = idx_ff + 1'b1;
            end
         end
         ST_ROOT: begin
            if (rt_n_ff >= rt_rb) begin
               rt_n_in = rt_n_ff - rt_rb;
               rt_r_in = (rt_r_ff >> 1) + rt_bit_ff;
            end else begin
               rt_r_in = rt_r_ff >> 1;
            end
            rt_bit_in = rt_bit_ff >> 2;
            cnt_in    = cnt_ff + 1'b1;
            if (cnt_ff == RC_W'(ROOT_STEPS - 1)) begin
               state_in = ST_VMUL;
            end
         end
         ST_VMUL: begin
            div_start    = 1'b1;
            div_dividend = mul_p + WW'(rt_r_ff[HW-1:1]);
            div_divisor  = rt_r_ff[HW-1:0];
            state_in     = ST_VDIV;
         end
         ST_VDIV: begin
            if (div_done) begin
               vert_in[idx_ff] = neg_ff[idx_ff] ? -$signed({1'b0, mag_q})
                                                :  $signed({1'b0, mag_q});
               if (idx_ff == 2'd2) begin
                  idx_in   = '0;
                  state_in = ST_TSQ;
               end else begin
                  idx_in   = idx_ff + 1'b1;
                  state_in = ST_VMUL;
               end
            end
         end
         ST_TSQ: begin
            sq_in    = mul_p[SQ_W-1:0];
            state_in = ST_TDEN;
         end
         ST_TDEN: begin
            den_in   = mul_p[HW-1:0];
            state_in = ST_TMUL;
         end
         ST_TMUL: begin
            div_start    = 1'b1;
            div_dividend = ((WW'(gt) + mul_p) << TW) + WW'(den_ff >> 1);
            div_divisor  = den_ff;
            state_in     = ST_TDIV;
         end
         ST_TDIV: begin
            if (div_done) begin
               tex_in[idx_ff[0]] = (|div_quo[WW-1:TW]) ? '1 : div_quo[TW-1:0];
               if (idx_ff == 2'd1) begin
                  idx_in   = '0;
                  state_in = ST_OUT;
               end else begin
                  idx_in   = idx_ff + 1'b1;
                  state_in = ST_TMUL;
               end
            end
         end
         ST_OUT: begin
            if (!rsp_valid_ff || rsp_bus.ready) begin
               for (int i = 0; i < 3; i++) begin
                  if (first_pt) begin
                     low_in[i]  = pos[i];
                     high_in[i] = pos[i];
                  end else begin
                     low_in[i]  = (pos[i] < low_ff[i])  ? pos[i] : low_ff[i];
                     high_in[i] = (pos[i] > high_ff[i]) ? pos[i] : high_ff[i];
                  end
               end
               rsp_low_in   = low_in;
               rsp_high_in  = high_in;
               rsp_vert_in  = vert_ff;
               rsp_tex_in   = tex_ff;
               rsp_done_in  = ({1'b0, row_ff} == CMP_W'(GRID_SIZE))
                           && ({1'b0, col_ff} == CMP_W'(GRID_SIZE));
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         idx_ff       <= '0;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
         radius_ff    <= '0;
         ofs_ff       <= '{default: '0};
         level_ff     <= '0;
         low_ff       <= '{default: '0};
         high_ff      <= '{default: '0};
      end else begin
         state_ff     <= state_in;
         idx_ff       <= idx_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
         radius_ff    <= radius_in;
         ofs_ff       <= ofs_in;
         level_ff     <= level_in;
         low_ff       <= low_in;
         high_ff      <= high_in;
      end
      cen_ff      <= cen_in;
      acr_ff      <= acr_in;
      dwn_ff      <= dwn_in;
      row_ff      <= row_in;
      col_ff      <= col_in;
      neg_ff      <= neg_in;
      mag_ff      <= mag_in;
      rt_n_ff     <= rt_n_in;
      rt_r_ff     <= rt_r_in;
      rt_bit_ff   <= rt_bit_in;
      vert_ff     <= vert_in;
      sq_ff       <= sq_in;
      den_ff      <= den_in;
      tex_ff      <= tex_in;
      rsp_vert_ff <= rsp_vert_in;
      rsp_tex_ff  <= rsp_tex_in;
      rsp_low_ff  <= rsp_low_in;
      rsp_high_ff <= rsp_high_in;
      rsp_done_ff <= rsp_done_in;
   end

   spvg_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_dividend),
      .divisor  (div_divisor),
      .done     (div_done),
      .quotient (div_quo)
   );

   assign req_bus.ready      = (state_ff == ST_IDLE);
   assign rsp_bus.valid      = rsp_valid_ff;
   assign rsp_bus.vertex_x   = rsp_vert_ff[0];
   assign rsp_bus.vertex_y   = rsp_vert_ff[1];
   assign rsp_bus.vertex_z   = rsp_vert_ff[2];
   assign rsp_bus.tex_s      = rsp_tex_ff[0];
   assign rsp_bus.tex_t      = rsp_tex_ff[1];
   assign rsp_bus.box_min_x  = rsp_low_ff[0];
   assign rsp_bus.box_max_x  = rsp_high_ff[0];
   assign rsp_bus.box_min_y  = rsp_low_ff[1];
   assign rsp_bus.box_max_y  = rsp_high_ff[1];
   assign rsp_bus.box_min_z  = rsp_low_ff[2];
   assign rsp_bus.box_max_z  = rsp_high_ff[2];
   assign rsp_bus.patch_done = rsp_done_ff;

   a_busy_after_request: assert property (@(posedge clock) disable iff (reset)
      (req_bus.valid && req_bus.ready) |=> !req_bus.ready)
      else $error("request taken while a previous one is in flight");

   a_norm_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SQR) |-> (mag_or[MW-1:NW] == '0))
      else $error("scaled magnitude exceeds normalized width");

   a_len_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_VMUL) |-> (WW'(mag_ff[idx_ff]) <= rt_r_ff))
      else $error("component magnitude above vector length");

   a_box_order: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> ((rsp_low_ff[0] <= rsp_high_ff[0]) && (rsp_low_ff[1] <= rsp_high_ff[1])
                        && (rsp_low_ff[2] <= rsp_high_ff[2])))
      else $error("bounding box min above max");

endmodule
